/* rtl/core/qlsf_pkg.sv */
// Shared types, constants and the solve microprogram for the quadratic fit.
// No dependencies; every other file in rtl/core imports this package.
package qlsf_pkg;

   localparam int MAX_POINTS = 4096;
   localparam int X_BITS     = 12;
   localparam int Y_BITS     = 16;
   localparam int FRAC_BITS  = 24;
   localparam int WIDE       = 256;
   localparam int STEP_BITS  = $clog2(WIDE);
   localparam int PC_BITS    = 6;
   localparam int COUNT_BITS = 13;

   typedef struct packed {
      logic signed [X_BITS-1:0] x_value;
      logic signed [Y_BITS-1:0] y_value;
      logic                     last_point;
   } req_data_type;

   typedef struct packed {
      logic [1:0]          status;
      logic signed [63:0]  coef_a;
      logic signed [63:0]  coef_b;
      logic signed [63:0]  coef_c;
   } rsp_data_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_EMPTY    = 2'd1,
      STAT_SINGULAR = 2'd2,
      STAT_OVERFLOW = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      OP_MUL, OP_SUB, OP_SHL, OP_DIV, OP_CHK, OP_END
   } op_type;

   typedef enum logic [4:0] {
      SRC_N, SRC_SX, SRC_SY, SRC_SX2, SRC_SX3, SRC_SX4, SRC_SXY, SRC_SX2Y,
      SRC_VXX, SRC_VXY, SRC_VXX2, SRC_VX2X2, SRC_VX2Y, SRC_DET, SRC_NB,
      SRC_NC, SRC_NA, SRC_T0, SRC_T1
   } src_type;

   typedef enum logic [3:0] {
      DST_NONE, DST_VXX, DST_VXY, DST_VXX2, DST_VX2X2, DST_VX2Y, DST_DET,
      DST_NB, DST_NC, DST_NA, DST_T0, DST_T1, DST_CA, DST_CB, DST_CC
   } dst_type;

   typedef struct packed {
      op_type  op;
      dst_type dst;
      src_type src_a;
      src_type src_b;
   } uop_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SQ, ST_ACC, ST_EVAL, ST_ISSUE, ST_WAIT, ST_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic       load_in;
      logic       sq_en;
      logic       acc_en;
      logic       go;
      uop_type    uop;
      logic       load_rsp;
      status_type status;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic busy;
      logic det_zero;
      logic overflow;
      logic count_zero;
      logic last;
   } dp_stat_type;

   function automatic uop_type mk(op_type o, dst_type d, src_type a, src_type b);
      uop_type u;
      u.op = o; u.dst = d; u.src_a = a; u.src_b = b;
      return u;
   endfunction

   // Solve program: centered moments, determinant, numerators, quotients.
   function automatic uop_type ucode(logic [PC_BITS-1:0] pc);
      uop_type u;
      case (pc)
         6'd0:  u = mk(OP_MUL, DST_T0,    SRC_N,    SRC_SX2);
         6'd1:  u = mk(OP_MUL, DST_T1,    SRC_SX,   SRC_SX);
         6'd2:  u = mk(OP_SUB, DST_VXX,   SRC_T0,   SRC_T1);
         6'd3:  u = mk(OP_MUL, DST_T0,    SRC_N,    SRC_SXY);
         6'd4:  u = mk(OP_MUL, DST_T1,    SRC_SX,   SRC_SY);
         6'd5:  u = mk(OP_SUB, DST_VXY,   SRC_T0,   SRC_T1);
         6'd6:  u = mk(OP_MUL, DST_T0,    SRC_N,    SRC_SX3);
         6'd7:  u = mk(OP_MUL, DST_T1,    SRC_SX,   SRC_SX2);
         6'd8:  u = mk(OP_SUB, DST_VXX2,  SRC_T0,   SRC_T1);
         6'd9:  u = mk(OP_MUL, DST_T0,    SRC_N,    SRC_SX4);
         6'd10: u = mk(OP_MUL, DST_T1,    SRC_SX2,  SRC_SX2);
         6'd11: u = mk(OP_SUB, DST_VX2X2, SRC_T0,   SRC_T1);
         6'd12: u = mk(OP_MUL, DST_T0,    SRC_N,    SRC_SX2Y);
         6'd13: u = mk(OP_MUL, DST_T1,    SRC_SX2,  SRC_SY);
         6'd14: u = mk(OP_SUB, DST_VX2Y,  SRC_T0,   SRC_T1);
         6'd15: u = mk(OP_MUL, DST_T0,    SRC_VXX,  SRC_VX2X2);
         6'd16: u = mk(OP_MUL, DST_T1,    SRC_VXX2, SRC_VXX2);
         6'd17: u = mk(OP_SUB, DST_DET,   SRC_T0,   SRC_T1);
         6'd18: u = mk(OP_CHK, DST_NONE,  SRC_DET,  SRC_DET);
         6'd19: u = mk(OP_MUL, DST_T0,    SRC_VXY,  SRC_VX2X2);
         6'd20: u = mk(OP_MUL, DST_T1,    SRC_VX2Y, SRC_VXX2);
         6'd21: u = mk(OP_SUB, DST_NB,    SRC_T0,   SRC_T1);
         6'd22: u = mk(OP_MUL, DST_T0,    SRC_VX2Y, SRC_VXX);
         6'd23: u = mk(OP_MUL, DST_T1,    SRC_VXY,  SRC_VXX2);
         6'd24: u = mk(OP_SUB, DST_NC,    SRC_T0,   SRC_T1);
         6'd25: u = mk(OP_MUL, DST_T0,    SRC_SY,   SRC_DET);
         6'd26: u = mk(OP_MUL, DST_T1,    SRC_NB,   SRC_SX);
         6'd27: u = mk(OP_SUB, DST_NA,    SRC_T0,   SRC_T1);
         6'd28: u = mk(OP_MUL, DST_T1,    SRC_NC,   SRC_SX2);
         6'd29: u = mk(OP_SUB, DST_NA,    SRC_NA,   SRC_T1);
         6'd30: u = mk(OP_SHL, DST_T0,    SRC_NB,   SRC_NB);
         6'd31: u = mk(OP_DIV, DST_CB,    SRC_T0,   SRC_DET);
         6'd32: u = mk(OP_SHL, DST_T0,    SRC_NC,   SRC_NC);
         6'd33: u = mk(OP_DIV, DST_CC,    SRC_T0,   SRC_DET);
         6'd34: u = mk(OP_MUL, DST_T1,    SRC_N,    SRC_DET);
         6'd35: u = mk(OP_SHL, DST_T0,    SRC_NA,   SRC_NA);
         6'd36: u = mk(OP_DIV, DST_CA,    SRC_T0,   SRC_T1);
         default: u = mk(OP_END, DST_NONE, SRC_N,   SRC_N);
      endcase
      return u;
   endfunction

endpackage

/* rtl/core/qlsf_datapath.sv */
// Datapath: point registers, moment accumulators, wide operand registers and
// a shared bit-serial multiply/divide unit. Depends on qlsf_pkg.
module qlsf_datapath import qlsf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  req_data_type req_data,
   input  cmd_type      cmd,
   output dp_stat_type  stat,
   output rsp_data_type rsp_data
);

   logic signed [X_BITS-1:0]     x_ff;
   logic signed [Y_BITS-1:0]     y_ff;
   logic                         last_ff;
   logic signed [2*X_BITS-1:0]   x2_ff;
   logic [COUNT_BITS-1:0]        count_ff;
   logic                         overflow_ff;
   logic signed [24:0]           sum_x_ff;
   logic signed [28:0]           sum_y_ff;
   logic signed [35:0]           sum_x_sq_ff;
   logic signed [45:0]           sum_x_cube_ff;
   logic signed [57:0]           sum_x_quad_ff;
   logic signed [39:0]           sum_xy_ff;
   logic signed [49:0]           sum_x_sq_y_ff;

   logic [WIDE-1:0] vxx_ff, vxy_ff, vxx2_ff, vx2x2_ff, vx2y_ff, det_ff;
   logic [WIDE-1:0] nb_ff, nc_ff, na_ff, t0_ff, t1_ff;
   logic [63:0]     coef_a_ff, coef_b_ff, coef_c_ff;

   // serial unit: acc = product or remainder, ma = multiplicand or divisor,
   // mb = multiplier or dividend/quotient
   logic [WIDE-1:0]      acc_ff, ma_ff, mb_ff;
   logic                 busy_ff, neg_ff;
   logic [STEP_BITS-1:0] step_ff;
   op_type               uop_ff;
   dst_type              udst_ff;
   rsp_data_type         rsp_ff;

   logic signed [2*X_BITS-1:0]        x2_in;
   logic signed [35:0]                x3;
   logic signed [47:0]                x4;
   logic signed [X_BITS+Y_BITS-1:0]   xy;
   logic signed [39:0]                x2y;
   logic [WIDE-1:0]                   opa, opb, mul_next, rem_sh, rem_new, num_new;
   logic                              div_ge;
   logic                              wb_en;
   dst_type                           wb_dst;
   logic [WIDE-1:0]                   wb_val;

   function automatic logic [WIDE-1:0] sel(src_type s, logic [WIDE-1:0] n_v,
         logic [WIDE-1:0] sx, logic [WIDE-1:0] sy, logic [WIDE-1:0] sx2,
         logic [WIDE-1:0] sx3, logic [WIDE-1:0] sx4, logic [WIDE-1:0] sxy,
         logic [WIDE-1:0] sx2y);
      logic [WIDE-1:0] r;
      case (s)
         SRC_N:     r = n_v;
         SRC_SX:    r = sx;
         SRC_SY:    r = sy;
         SRC_SX2:   r = sx2;
         SRC_SX3:   r = sx3;
         SRC_SX4:   r = sx4;
         SRC_SXY:   r = sxy;
         SRC_SX2Y:  r = sx2y;
         SRC_VXX:   r = vxx_ff;
         SRC_VXY:   r = vxy_ff;
         SRC_VXX2:  r = vxx2_ff;
         SRC_VX2X2: r = vx2x2_ff;
         SRC_VX2Y:  r = vx2y_ff;
         SRC_DET:   r = det_ff;
         SRC_NB:    r = nb_ff;
         SRC_NC:    r = nc_ff;
         SRC_NA:    r = na_ff;
         SRC_T0:    r = t0_ff;
         SRC_T1:    r = t1_ff;
         default:   r = '0;
      endcase
      return r;
   endfunction

   function automatic logic [WIDE-1:0] mag(logic [WIDE-1:0] v);
      return v[WIDE-1] ? (~v + WIDE'(1)) : v;
   endfunction

   // truncated quotient magnitude -> saturated signed 64
   function automatic logic [63:0] sat(logic [WIDE-1:0] q, logic neg);
      logic [63:0] r;
      if (q[WIDE-1:64] != '0) begin
         r = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      end else if (!neg) begin
         r = q[63] ? 64'h7FFF_FFFF_FFFF_FFFF : q[63:0];
      end else if (q[63:0] > 64'h8000_0000_0000_0000) begin
         r = 64'h8000_0000_0000_0000;
      end else begin
         r = ~q[63:0] + 64'd1;
      end
      return r;
   endfunction

   assign x2_in = (2*X_BITS)'(x_ff) * (2*X_BITS)'(x_ff);
   assign x3    = 36'(x2_ff) * 36'(x_ff);
   assign x4    = 48'(x2_ff) * 48'(x2_ff);
   assign xy    = (X_BITS+Y_BITS)'(x_ff) * (X_BITS+Y_BITS)'(y_ff);
   assign x2y   = 40'(x2_ff) * 40'(y_ff);

   always_comb begin
      opa = sel(cmd.uop.src_a, WIDE'(count_ff), WIDE'(sum_x_ff), WIDE'(sum_y_ff),
                WIDE'(sum_x_sq_ff), WIDE'(sum_x_cube_ff), WIDE'(sum_x_quad_ff),
                WIDE'(sum_xy_ff), WIDE'(sum_x_sq_y_ff));
      opb = sel(cmd.uop.src_b, WIDE'(count_ff), WIDE'(sum_x_ff), WIDE'(sum_y_ff),
                WIDE'(sum_x_sq_ff), WIDE'(sum_x_cube_ff), WIDE'(sum_x_quad_ff),
                WIDE'(sum_xy_ff), WIDE'(sum_x_sq_y_ff));
   end

   assign mul_next = acc_ff + (mb_ff[0] ? ma_ff : '0);
   assign rem_sh   = {acc_ff[WIDE-2:0], mb_ff[WIDE-1]};
   assign div_ge   = rem_sh >= ma_ff;
   assign rem_new  = div_ge ? (rem_sh - ma_ff) : rem_sh;
   assign num_new  = {mb_ff[WIDE-2:0], div_ge};

   // write-back: subtract and shift ops on issue, serial ops on their last step
   always_comb begin
      wb_en  = 1'b0;
      wb_dst = cmd.uop.dst;
      wb_val = opa - opb;
      if (cmd.go && cmd.uop.op == OP_SUB) begin
         wb_en = 1'b1;
      end else if (cmd.go && cmd.uop.op == OP_SHL) begin
         wb_en  = 1'b1;
         wb_val = opa << FRAC_BITS;
      end else if (busy_ff && step_ff == '1) begin
         wb_en  = 1'b1;
         wb_dst = udst_ff;
         wb_val = (uop_ff == OP_DIV) ? WIDE'(sat(num_new, neg_ff)) : mul_next;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         x_ff    <= req_data.x_value;
         y_ff    <= req_data.y_value;
         last_ff <= req_data.last_point;
      end
      if (cmd.sq_en) begin
         x2_ff <= x2_in;
      end
      if (wb_en) begin
         case (wb_dst)
            DST_VXX:   vxx_ff    <= wb_val;
            DST_VXY:   vxy_ff    <= wb_val;
            DST_VXX2:  vxx2_ff   <= wb_val;
            DST_VX2X2: vx2x2_ff  <= wb_val;
            DST_VX2Y:  vx2y_ff   <= wb_val;
            DST_DET:   det_ff    <= wb_val;
            DST_NB:    nb_ff     <= wb_val;
            DST_NC:    nc_ff     <= wb_val;
            DST_NA:    na_ff     <= wb_val;
            DST_T0:    t0_ff     <= wb_val;
            DST_T1:    t1_ff     <= wb_val;
            DST_CA:    coef_a_ff <= wb_val[63:0];
            DST_CB:    coef_b_ff <= wb_val[63:0];
            DST_CC:    coef_c_ff <= wb_val[63:0];
            default: ;
         endcase
      end
      if (cmd.go) begin
         uop_ff  <= cmd.uop.op;
         udst_ff <= cmd.uop.dst;
         step_ff <= '0;
         acc_ff  <= '0;
         neg_ff  <= opa[WIDE-1] ^ opb[WIDE-1];
         if (cmd.uop.op == OP_DIV) begin
            ma_ff <= mag(opb);
            mb_ff <= mag(opa);
         end else begin
            ma_ff <= opa;
            mb_ff <= opb;
         end
      end else if (busy_ff) begin
         step_ff <= step_ff + STEP_BITS'(1);
         if (uop_ff == OP_DIV) begin
            acc_ff <= rem_new;
            mb_ff  <= num_new;
         end else begin
            acc_ff <= mul_next;
            ma_ff  <= ma_ff << 1;
            mb_ff  <= mb_ff >> 1;
         end
      end
      if (cmd.load_rsp) begin
         rsp_ff.status <= cmd.status;
         rsp_ff.coef_a <= (cmd.status == STAT_OK) ? coef_a_ff : '0;
         rsp_ff.coef_b <= (cmd.status == STAT_OK) ? coef_b_ff : '0;
         rsp_ff.coef_c <= (cmd.status == STAT_OK) ? coef_c_ff : '0;
      end
   end

   // control state: accumulators and serial unit busy flag
   always_ff @(posedge clock) begin
      if (reset || cmd.load_rsp) begin
         count_ff      <= '0;
         overflow_ff   <= 1'b0;
         sum_x_ff      <= '0;
         sum_y_ff      <= '0;
         sum_x_sq_ff   <= '0;
         sum_x_cube_ff <= '0;
         sum_x_quad_ff <= '0;
         sum_xy_ff     <= '0;
         sum_x_sq_y_ff <= '0;
      end else if (cmd.acc_en) begin
         if (count_ff >= COUNT_BITS'(MAX_POINTS)) begin
            overflow_ff <= 1'b1;
         end else begin
            count_ff      <= count_ff + COUNT_BITS'(1);
            sum_x_ff      <= sum_x_ff + 25'(x_ff);
            sum_y_ff      <= sum_y_ff + 29'(y_ff);
            sum_x_sq_ff   <= sum_x_sq_ff + 36'(x2_ff);
            sum_x_cube_ff <= sum_x_cube_ff + 46'(x3);
            sum_x_quad_ff <= sum_x_quad_ff + 58'(x4);
            sum_xy_ff     <= sum_xy_ff + 40'(xy);
            sum_x_sq_y_ff <= sum_x_sq_y_ff + 50'(x2y);
         end
      end
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (cmd.go) begin
         busy_ff <= (cmd.uop.op == OP_MUL) || (cmd.uop.op == OP_DIV);
      end else if (busy_ff && step_ff == '1) begin
         busy_ff <= 1'b0;
      end
   end

   assign stat.busy       = busy_ff;
   assign stat.det_zero   = (det_ff == '0);
   assign stat.overflow   = overflow_ff;
   assign stat.count_zero = (count_ff == '0);
   assign stat.last       = last_ff;
   assign rsp_data        = rsp_ff;

endmodule

/* rtl/core/qlsf_controller.sv */
// Controller: point sequencing, solve microprogram counter, result handshake.
// Depends on qlsf_pkg.
module qlsf_controller import qlsf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  dp_stat_type stat,
   output cmd_type     cmd
);

   state_type            state_ff, state_in;
   logic [PC_BITS-1:0]   pc_ff, pc_in;
   status_type           status_ff, status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   uop_type              uop;

   assign uop = ucode(pc_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= '0;
         status_ff    <= STAT_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      pc_in        = pc_ff;
      status_in    = status_ff;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.uop      = uop;
      cmd.status   = status_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_SQ;
            end
         end
         ST_SQ: begin
            cmd.sq_en = 1'b1;
            state_in  = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc_en = 1'b1;
            state_in   = stat.last ? ST_EVAL : ST_IDLE;
         end
         ST_EVAL: begin
            pc_in = '0;
            if (stat.overflow) begin
               status_in = STAT_OVERFLOW;
               state_in  = ST_DONE;
            end else if (stat.count_zero) begin
               status_in = STAT_EMPTY;
               state_in  = ST_DONE;
            end else begin
               status_in = STAT_OK;
               state_in  = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            case (uop.op)
               OP_END: state_in = ST_DONE;
               OP_CHK: begin
                  if (stat.det_zero) begin
                     status_in = STAT_SINGULAR;
                     state_in  = ST_DONE;
                  end else begin
                     pc_in = pc_ff + PC_BITS'(1);
                  end
               end
               default: begin
                  cmd.go   = 1'b1;
                  state_in = ST_WAIT;
               end
            endcase
         end
         ST_WAIT: begin
            if (!stat.busy) begin
               pc_in    = pc_ff + PC_BITS'(1);
               state_in = ST_ISSUE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = cmd.load_rsp ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/core/quadratic_least_squares_fit.sv */
// Top level of the quadratic least-squares fitter.
// Depends on qlsf_pkg, qlsf_controller and qlsf_datapath.
//
// Points (x, y) are accepted one beat at a time on req_; each point is latched,
// squared and then multiply-accumulated into exact moment sums, and no new
// point is taken until the last one is accumulated. The beat with last_point
// set closes the set: when the set is in range the block solves
// y = a + b*x + c*x^2 on one shared bit-serial unit that does a 256-bit
// multiply or signed divide. The solve program runs 20 multiplies, 3 divides,
// 10 subtracts and 3 shifts, during which no point is taken. Coefficients are
// signed Q40.24, truncated toward zero and saturated; status reports an
// over-full set (points past 4096 are dropped), an empty set, or a zero
// determinant, with all coefficients zero. The result sits in an output
// register until rsp_ready takes it; new points are accepted meanwhile. All
// sums clear when a result is produced.
module quadratic_least_squares_fit import qlsf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_data_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_data_type rsp_data
);

   cmd_type     cmd;
   dp_stat_type stat;

   qlsf_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   qlsf_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule
